>>> rtl/websocket_frame_builder_core_macros.svh
// Assertion macros used by the checker file of the frame builder.
`ifndef WEBSOCKET_FRAME_BUILDER_CORE_MACROS_SVH
`define WEBSOCKET_FRAME_BUILDER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSFB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("frame builder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WSFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("frame builder check failed");

`endif

>>> rtl/wsfb_pkg.sv
// Types and constants shared by the frame builder modules.
package wsfb_pkg;

  localparam logic       CMD_START  = 1'b0;
  localparam logic       CMD_DATA   = 1'b1;
  localparam logic [7:0] FIN_BIT    = 8'h80;
  localparam logic [6:0] LEN16_CODE = 7'd126;
  localparam logic [6:0] LEN64_CODE = 7'd127;
  localparam logic [15:0] LEN16_MAX = 16'hffff;
  localparam logic [3:0] LEN16_BYTES = 4'd2;
  localparam logic [3:0] LEN64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES  = 4'd4;

  typedef enum logic {
    KIND_HDR,
    KIND_DATA
  } wsfb_kind_e;

  // One job for the back end: a whole header, or one finished payload byte.
  typedef struct packed {
    wsfb_kind_e  kind;
    logic [7:0]  byte0;      // first header byte, or the payload byte
    logic [7:0]  byte1;      // mask bit and length code
    logic        frame_end;  // data: last byte; header: empty frame
    logic [3:0]  len_bytes;  // 0, 2 or 8 extended length bytes
    logic        masked;
    logic [62:0] len;
    logic [31:0] key;
  } wsfb_entry_t;

endpackage

>>> rtl/wsfb_queue.sv
// Small register queue of jobs between the front and back ends.
module wsfb_queue
  import wsfb_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  wsfb_entry_t entry_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output wsfb_entry_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  wsfb_entry_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

>>> rtl/wsfb_front.sv
// Front end: takes requests, tracks the open frame and masks payload bytes.
module wsfb_front
  import wsfb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        mask_frames_i,
  input  logic        command_i,
  input  logic [3:0]  opcode_i,
  input  logic        compressed_i,
  input  logic [62:0] payload_length_i,
  input  logic [31:0] mask_key_i,
  input  logic [7:0]  data_byte_i,
  output logic        q_push_o,
  output wsfb_entry_t q_entry_o
);

  logic        frame_open_q, frame_open_d;
  logic [62:0] bytes_left_q, bytes_left_d;
  logic [31:0] held_key_q, held_key_d;
  logic [1:0]  key_phase_q, key_phase_d;
  logic        masking_now_q, masking_now_d;

  logic        is_start, live;
  logic        len_short, len_mid;
  logic [6:0]  len_code;
  logic [3:0]  len_bytes;
  logic [7:0]  key_byte;
  logic [62:0] left_next;

  assign is_start  = (command_i == CMD_START);
  assign live      = frame_open_q && (bytes_left_q != '0);
  assign len_short = (payload_length_i < 63'(LEN16_CODE));
  assign len_mid   = (payload_length_i <= 63'(LEN16_MAX));
  assign left_next = bytes_left_q - 63'd1;

  always_comb begin
    if (len_short) begin
      len_code  = payload_length_i[6:0];
      len_bytes = '0;
    end else if (len_mid) begin
      len_code  = LEN16_CODE;
      len_bytes = LEN16_BYTES;
    end else begin
      len_code  = LEN64_CODE;
      len_bytes = LEN64_BYTES;
    end
  end

  // Key is applied most significant byte first.
  always_comb begin
    unique case (key_phase_q)
      2'd0:    key_byte = held_key_q[31:24];
      2'd1:    key_byte = held_key_q[23:16];
      2'd2:    key_byte = held_key_q[15:8];
      default: key_byte = held_key_q[7:0];
    endcase
  end

  always_comb begin
    q_entry_o = '0;
    if (is_start) begin
      q_entry_o.kind      = KIND_HDR;
      q_entry_o.byte0     = FIN_BIT | {1'b0, compressed_i, 2'b00, opcode_i};
      q_entry_o.byte1     = {mask_frames_i, len_code};
      q_entry_o.frame_end = (payload_length_i == '0);
      q_entry_o.len_bytes = len_bytes;
      q_entry_o.masked    = mask_frames_i;
      q_entry_o.len       = payload_length_i;
      q_entry_o.key       = mask_key_i;
    end else begin
      q_entry_o.kind      = KIND_DATA;
      q_entry_o.byte0     = data_byte_i ^ (masking_now_q ? key_byte : 8'h00);
      q_entry_o.frame_end = (left_next == '0);
    end
  end

  assign q_push_o = accept_i && (is_start || live);

  always_comb begin
    frame_open_d  = frame_open_q;
    bytes_left_d  = bytes_left_q;
    held_key_d    = held_key_q;
    key_phase_d   = key_phase_q;
    masking_now_d = masking_now_q;
    if (accept_i) begin
      priority if (is_start) begin
        masking_now_d = mask_frames_i;
        held_key_d    = mask_key_i;
        key_phase_d   = '0;
        bytes_left_d  = payload_length_i;
        frame_open_d  = (payload_length_i != '0);
      end else if (!live) begin
        frame_open_d = 1'b0;   // stray byte, dropped
      end else begin
        key_phase_d  = key_phase_q + 2'd1;
        bytes_left_d = left_next;
        if (left_next == '0) begin
          frame_open_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q  <= 1'b0;
      bytes_left_q  <= '0;
      held_key_q    <= '0;
      key_phase_q   <= '0;
      masking_now_q <= 1'b0;
    end else begin
      frame_open_q  <= frame_open_d;
      bytes_left_q  <= bytes_left_d;
      held_key_q    <= held_key_d;
      key_phase_q   <= key_phase_d;
      masking_now_q <= masking_now_d;
    end
  end

endmodule

>>> rtl/wsfb_back.sv
// Back end: walks header jobs byte by byte and drives the output register.
module wsfb_back
  import wsfb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        entry_valid_i,
  input  wsfb_entry_t entry_i,
  output logic        entry_pop_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o
);

  logic [3:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_end_q, out_end_d;

  logic        advance, is_last;
  logic [3:0]  last_idx, len_k, len_end, key_j;
  logic [2:0]  len_pos;
  logic [63:0] len_word;
  logic [7:0]  len_byte, key_byte, hdr_byte;

  assign last_idx = 4'd1 + entry_i.len_bytes + (entry_i.masked ? KEY_BYTES : 4'd0);
  assign len_end  = 4'd2 + entry_i.len_bytes;
  assign len_k    = idx_q - 4'd2;
  assign len_pos  = 3'(entry_i.len_bytes - 4'd1 - len_k);
  assign len_word = {1'b0, entry_i.len} >> {len_pos, 3'b000};
  assign len_byte = len_word[7:0];
  assign key_j    = idx_q - len_end;

  always_comb begin
    unique case (key_j[1:0])
      2'd0:    key_byte = entry_i.key[31:24];
      2'd1:    key_byte = entry_i.key[23:16];
      2'd2:    key_byte = entry_i.key[15:8];
      default: key_byte = entry_i.key[7:0];
    endcase
  end

  always_comb begin
    priority if (idx_q == 4'd0) begin
      hdr_byte = entry_i.byte0;
    end else if (idx_q == 4'd1) begin
      hdr_byte = entry_i.byte1;
    end else if (idx_q < len_end) begin
      hdr_byte = len_byte;
    end else begin
      hdr_byte = key_byte;
    end
  end

  assign is_last     = (entry_i.kind == KIND_DATA) || (idx_q == last_idx);
  assign advance     = entry_valid_i && (!out_valid_q || pop_i);
  assign entry_pop_o = advance && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !pop_i;
    out_byte_d  = out_byte_q;
    out_end_d   = out_end_q;
    if (advance) begin
      out_valid_d = 1'b1;
      out_end_d   = is_last && entry_i.frame_end;
      out_byte_d  = (entry_i.kind == KIND_DATA) ? entry_i.byte0 : hdr_byte;
      idx_d       = is_last ? 4'd0 : idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_end_q  <= out_end_d;
  end

  assign empty_o     = !out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign frame_end_o = out_end_q;

endmodule

>>> rtl/websocket_frame_builder_core.sv
// WebSocket (RFC 6455) frame builder: turns start and payload requests into
// a byte stream on a queue-style output. Payload bytes pass at one per cycle
// while the output is taken; each byte goes through the job queue and then
// the output register. A start request yields 2 to 14 header bytes (first
// byte, length code, 0/2/8 length bytes, 4 key bytes when masking), sent one
// per cycle while the output is taken, by the header walker in the back end.
// The header job stays in the job queue while it is walked, so up to
// QueueDepth - 1 later requests are taken before full rises.
// mask_frames is sampled at each start; cfg_ready_o is always high.
module websocket_frame_builder_core
  import wsfb_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic        command_i,
  input  logic [3:0]  opcode_i,
  input  logic        compressed_i,
  input  logic [62:0] payload_length_i,
  input  logic [31:0] mask_key_i,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o
);

  logic        mask_frames_q;
  logic        accept;
  logic        q_push, q_full, q_valid, q_pop;
  wsfb_entry_t q_in, q_out;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;
  assign accept      = push && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_frames_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mask_frames_q <= cfg_data_i;
    end
  end

  wsfb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .mask_frames_i    (mask_frames_q),
    .command_i        (command_i),
    .opcode_i         (opcode_i),
    .compressed_i     (compressed_i),
    .payload_length_i (payload_length_i),
    .mask_key_i       (mask_key_i),
    .data_byte_i      (data_byte_i),
    .q_push_o         (q_push),
    .q_entry_o        (q_in)
  );

  wsfb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_out)
  );

  wsfb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (q_valid),
    .entry_i       (q_out),
    .entry_pop_o   (q_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .out_byte_o    (out_byte_o),
    .frame_end_o   (frame_end_o)
  );

endmodule

>>> rtl/wsfb_checker.sv
// Port-level checks for the frame builder, bound to the top level.
`include "websocket_frame_builder_core_macros.svh"

module wsfb_checker
  import wsfb_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic        cfg_data_i,
  input logic        push,
  input logic        full,
  input logic        command_i,
  input logic [3:0]  opcode_i,
  input logic        compressed_i,
  input logic [62:0] payload_length_i,
  input logic [31:0] mask_key_i,
  input logic [7:0]  data_byte_i,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_byte_o,
  input logic        frame_end_o
);

  // A waiting result holds until it is taken.
  `WSFB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_byte_o) && $stable(frame_end_o))

  // A taken start request always has a result showing once it has passed the job queue and output register.
  `WSFB_ASSERT_IMPLIES(a_start_shows, clk_i, rst_ni, push && !full && command_i == CMD_START, ##2 !empty)

  // The job queue only fills up behind a result that is already showing.
  `WSFB_ASSERT_IMPLIES(a_full_not_empty, clk_i, rst_ni, full, !empty)

endmodule

bind websocket_frame_builder_core wsfb_checker u_checker (.*);
